@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// clocked property checks that compile away for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ src/rle_pkg.sv @@
// ---------------------------------------------------------------------------
// rle_pkg
// shared types and constants of the rgb lamp effect engine
// ---------------------------------------------------------------------------
package rle_pkg;

  typedef enum logic [2:0] {
    MODE_CONST     = 3'd0,
    MODE_RGB_CYCLE = 3'd1,
    MODE_BLINK     = 3'd2,
    MODE_BREATHE   = 3'd3,
    MODE_WHEEL     = 3'd4,
    MODE_WAKE      = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_MODE   = 3'd1,
    ACT_COLOUR = 3'd2,
    ACT_POWER  = 3'd3,
    ACT_ONOFF  = 3'd4
  } act_e;

  typedef enum logic [2:0] {
    CFG_FLASH_RATE    = 3'd0,
    CFG_STROBE_RATE   = 3'd1,
    CFG_FADE_RATE     = 3'd2,
    CFG_SMOOTH_RATE   = 3'd3,
    CFG_WAKEUP_PERIOD = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [6:0]  FULL_LEVEL = 7'd100;
  localparam logic [6:0]  RST_LEVEL  = 7'd50;

  localparam logic [23:0] COL_BLACK   = 24'h000000;
  localparam logic [23:0] COL_RED     = 24'hFF0000;
  localparam logic [23:0] COL_GREEN   = 24'h00FF00;
  localparam logic [23:0] COL_BLUE    = 24'h0000FF;
  localparam logic [23:0] COL_WHITE   = 24'hFFFFFF;
  localparam logic [23:0] COL_YELLOW  = 24'hFFFF00;
  localparam logic [23:0] COL_CYAN    = 24'h00FFFF;
  localparam logic [23:0] COL_MAGENTA = 24'hFF00FF;
  localparam logic [23:0] STEP_R      = 24'h010000;
  localparam logic [23:0] STEP_G      = 24'h000100;
  localparam logic [23:0] STEP_B      = 24'h000001;

  localparam logic signed [7:0] RST_FLASH_RATE  = 8'sd0;
  localparam logic signed [7:0] RST_STROBE_RATE = 8'sd0;
  localparam logic [6:0]        RST_FADE_RATE   = 7'd75;
  localparam logic [6:0]        RST_SMOOTH_RATE = 7'd80;
  localparam logic [15:0]       RST_WAKEUP      = 16'd1000;

  typedef struct packed {
    logic [2:0]  action;
    logic [23:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0] red_duty;
    logic [7:0] green_duty;
    logic [7:0] blue_duty;
    logic [2:0] mode_now;
  } out_t;

  typedef struct packed {
    logic signed [7:0] flash_rate;
    logic signed [7:0] strobe_rate;
    logic [6:0]        fade_rate;
    logic [6:0]        smooth_rate;
    logic [15:0]       wakeup_period;
  } cfg_t;

  // lamp state after the current word, as seen by the scaler
  typedef struct packed {
    mode_e       mode;
    logic        on;
    logic [6:0]  level;
    logic [23:0] colour;
  } view_t;

endpackage

@@ src/rle_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// rle_cfg_regs
// effect speed registers behind the configuration write port
// ---------------------------------------------------------------------------
module rle_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [rle_pkg::CfgIdxW-1:0]  wr_idx_i,
  input  logic [rle_pkg::CfgDataW-1:0] wr_data_i,
  output rle_pkg::cfg_t                cfg_o
);

  rle_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (rle_pkg::cfg_idx_e'(wr_idx_i))
        rle_pkg::CFG_FLASH_RATE:    cfg_d.flash_rate    = $signed(wr_data_i[7:0]);
        rle_pkg::CFG_STROBE_RATE:   cfg_d.strobe_rate   = $signed(wr_data_i[7:0]);
        rle_pkg::CFG_FADE_RATE:     cfg_d.fade_rate     = wr_data_i[6:0];
        rle_pkg::CFG_SMOOTH_RATE:   cfg_d.smooth_rate   = wr_data_i[6:0];
        rle_pkg::CFG_WAKEUP_PERIOD: cfg_d.wakeup_period = wr_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flash_rate    <= rle_pkg::RST_FLASH_RATE;
      cfg_q.strobe_rate   <= rle_pkg::RST_STROBE_RATE;
      cfg_q.fade_rate     <= rle_pkg::RST_FADE_RATE;
      cfg_q.smooth_rate   <= rle_pkg::RST_SMOOTH_RATE;
      cfg_q.wakeup_period <= rle_pkg::RST_WAKEUP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/rle_effect.sv @@
// ---------------------------------------------------------------------------
// rle_effect
// lamp state registers and the per-word command / effect update
// ---------------------------------------------------------------------------
module rle_effect (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  rle_pkg::in_t  item_i,
  input  rle_pkg::cfg_t cfg_i,
  output rle_pkg::view_t view_o
);

  rle_pkg::mode_e mode_d, mode_q, prev_d, prev_q;
  logic [2:0]     phase_d, phase_q;
  logic [15:0]    tcnt_d, tcnt_q;
  logic [23:0]    colour_d, colour_q, scol_d, scol_q;
  logic [6:0]     level_d, level_q, slev_d, slev_q;
  logic           on_d, on_q;

  logic signed [17:0] thr;
  logic               expired;

  // divider threshold of the running effect
  always_comb begin
    case (mode_q)
      rle_pkg::MODE_RGB_CYCLE: thr = 18'sd100 - 18'(cfg_i.flash_rate);
      rle_pkg::MODE_BLINK:     thr = 18'sd100 - 18'(cfg_i.strobe_rate);
      rle_pkg::MODE_BREATHE:   thr = 18'sd100 - $signed({11'd0, cfg_i.fade_rate});
      rle_pkg::MODE_WHEEL:     thr = 18'sd100 - $signed({11'd0, cfg_i.smooth_rate});
      rle_pkg::MODE_WAKE:      thr = $signed({2'd0, cfg_i.wakeup_period});
      default:                 thr = '0;
    endcase
  end

  always_comb begin
    mode_d   = mode_q;
    prev_d   = prev_q;
    phase_d  = phase_q;
    tcnt_d   = tcnt_q;
    colour_d = colour_q;
    level_d  = level_q;
    scol_d   = scol_q;
    slev_d   = slev_q;
    on_d     = on_q;
    expired  = 1'b0;
    if (step_i) begin
      case (rle_pkg::act_e'(item_i.action))
        rle_pkg::ACT_TICK: begin
          // back in constant: restore what the effect saved
          if (mode_d == rle_pkg::MODE_CONST && prev_d != rle_pkg::MODE_CONST) begin
            prev_d   = rle_pkg::MODE_CONST;
            colour_d = scol_q;
            level_d  = slev_q;
          end
          if (on_q && mode_d != rle_pkg::MODE_CONST) begin
            // first tick of a new effect
            if (prev_d != mode_d) begin
              if (prev_d == rle_pkg::MODE_CONST) begin
                scol_d = colour_d;
                slev_d = level_d;
              end
              tcnt_d = '0;
              prev_d = mode_d;
              case (mode_d)
                rle_pkg::MODE_RGB_CYCLE: begin
                  phase_d  = 3'd0;
                  colour_d = rle_pkg::COL_RED;
                end
                rle_pkg::MODE_BLINK: begin
                  phase_d  = 3'd0;
                  colour_d = rle_pkg::COL_WHITE;
                end
                rle_pkg::MODE_BREATHE: begin
                  phase_d  = 3'd1;
                  colour_d = rle_pkg::COL_WHITE;
                  level_d  = '0;
                end
                rle_pkg::MODE_WHEEL: begin
                  phase_d  = 3'd0;
                  colour_d = rle_pkg::COL_RED;
                end
                rle_pkg::MODE_WAKE: begin
                  colour_d = rle_pkg::COL_BLUE;
                  level_d  = '0;
                end
                default: ;
              endcase
            end
            expired = !($signed({2'd0, tcnt_d}) < thr);
            tcnt_d  = expired ? '0 : tcnt_d + 16'd1;
            if (expired) begin
              case (mode_d)
                rle_pkg::MODE_RGB_CYCLE: begin
                  phase_d = (phase_d >= 3'd2) ? 3'd0 : phase_d + 3'd1;
                  if (phase_d == 3'd0)      colour_d = rle_pkg::COL_RED;
                  else if (phase_d == 3'd1) colour_d = rle_pkg::COL_GREEN;
                  else                      colour_d = rle_pkg::COL_BLUE;
                end
                rle_pkg::MODE_BLINK: begin
                  phase_d  = (phase_d == 3'd0) ? 3'd1 : 3'd0;
                  colour_d = (phase_d != 3'd0) ? rle_pkg::COL_WHITE : rle_pkg::COL_BLACK;
                end
                rle_pkg::MODE_BREATHE: begin
                  if (phase_d != 3'd0) begin
                    if (level_d < rle_pkg::FULL_LEVEL) level_d = level_d + 7'd1;
                  end else if (level_d != 7'd0) begin
                    level_d = level_d - 7'd1;
                  end
                  if (level_d >= rle_pkg::FULL_LEVEL) phase_d = 3'd0;
                  else if (level_d == 7'd0)           phase_d = 3'd1;
                end
                rle_pkg::MODE_WHEEL: begin
                  case (phase_d)
                    3'd0: if (colour_d == rle_pkg::COL_YELLOW) phase_d = 3'd1;
                          else colour_d = colour_d + rle_pkg::STEP_G;
                    3'd1: if (colour_d == rle_pkg::COL_GREEN) phase_d = 3'd2;
                          else colour_d = colour_d - rle_pkg::STEP_R;
                    3'd2: if (colour_d == rle_pkg::COL_CYAN) phase_d = 3'd3;
                          else colour_d = colour_d + rle_pkg::STEP_B;
                    3'd3: if (colour_d == rle_pkg::COL_BLUE) phase_d = 3'd4;
                          else colour_d = colour_d - rle_pkg::STEP_G;
                    3'd4: if (colour_d == rle_pkg::COL_MAGENTA) phase_d = 3'd5;
                          else colour_d = colour_d + rle_pkg::STEP_R;
                    3'd5: if (colour_d == rle_pkg::COL_RED) phase_d = 3'd0;
                          else colour_d = colour_d - rle_pkg::STEP_B;
                    default: phase_d = 3'd0;
                  endcase
                end
                rle_pkg::MODE_WAKE: begin
                  if (level_d < rle_pkg::FULL_LEVEL) level_d = level_d + 7'd1;
                  if (level_d >= rle_pkg::FULL_LEVEL) begin
                    scol_d = colour_d;
                    slev_d = level_d;
                    mode_d = rle_pkg::MODE_CONST;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        rle_pkg::ACT_MODE: begin
          if (item_i.value <= 24'(rle_pkg::MODE_WAKE)) begin
            mode_d = rle_pkg::mode_e'(item_i.value[2:0]);
          end
        end
        rle_pkg::ACT_COLOUR: colour_d = item_i.value;
        rle_pkg::ACT_POWER: begin
          level_d = (item_i.value > 24'(rle_pkg::FULL_LEVEL)) ? rle_pkg::FULL_LEVEL
                                                              : item_i.value[6:0];
        end
        rle_pkg::ACT_ONOFF: on_d = item_i.value[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= rle_pkg::MODE_CONST;
      prev_q   <= rle_pkg::MODE_CONST;
      phase_q  <= '0;
      tcnt_q   <= '0;
      colour_q <= rle_pkg::COL_WHITE;
      level_q  <= rle_pkg::RST_LEVEL;
      scol_q   <= '0;
      slev_q   <= '0;
      on_q     <= 1'b0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      prev_q   <= prev_d;
      phase_q  <= phase_d;
      tcnt_q   <= tcnt_d;
      colour_q <= colour_d;
      level_q  <= level_d;
      scol_q   <= scol_d;
      slev_q   <= slev_d;
      on_q     <= on_d;
    end
  end

  assign view_o.mode   = mode_d;
  assign view_o.on     = on_d;
  assign view_o.level  = level_d;
  assign view_o.colour = colour_d;

endmodule

@@ src/rle_scale.sv @@
// ---------------------------------------------------------------------------
// rle_scale
// channel times power over one hundred, floored, zero when the lamp is off
// ---------------------------------------------------------------------------
module rle_scale (
  input  rle_pkg::view_t view_i,
  output rle_pkg::out_t  data_o
);

  // ceil(2^19 / 100); exact floor for every 8 bit channel and level up to 100
  localparam int unsigned FracBits = 19;
  localparam logic [12:0] Recip100 = 13'd5243;

  logic [19:0] lvl_k;

  function automatic logic [7:0] scale_ch(input logic [7:0] c, input logic [19:0] k);
    logic [27:0] p;
    p = {20'd0, c} * {8'd0, k};
    return p[FracBits+7:FracBits];
  endfunction

  assign lvl_k = {13'd0, view_i.level} * {7'd0, Recip100};

  always_comb begin
    data_o.mode_now = view_i.mode;
    if (view_i.on) begin
      data_o.red_duty   = scale_ch(view_i.colour[23:16], lvl_k);
      data_o.green_duty = scale_ch(view_i.colour[15:8], lvl_k);
      data_o.blue_duty  = scale_ch(view_i.colour[7:0], lvl_k);
    end else begin
      data_o.red_duty   = '0;
      data_o.green_duty = '0;
      data_o.blue_duty  = '0;
    end
  end

endmodule

@@ src/rgb_led_effect_engine.sv @@
// ---------------------------------------------------------------------------
// rgb_led_effect_engine
// per-tick rgb lamp effect generator with power scaled pwm levels
// ---------------------------------------------------------------------------
// Every input word is a 1 ms tick or a command (mode, colour, power, on/off)
// and gives exactly one result word: the three pwm duties, each channel times
// power / 100 floored (zero while the lamp is off), plus the mode in force.
// A word is taken into an input register, then one pass of update logic
// (command decode, effect divider and step, power scaling with one 8x20
// multiply per channel) writes the lamp state and the output register in the
// same edge. One word is accepted per cycle unless in_stall_o is high; the
// output register raises out_valid_o with its result and lets the next word
// move in as soon as the current result is taken. Speed registers are written
// through the cfg port (ready always high); the user must write them only
// while no word is in flight, which the block itself does not enforce.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_led_effect_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input words
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  rle_pkg::in_t                 in_data_i,
  // result words
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output rle_pkg::out_t                out_data_o,
  // configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rle_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rle_pkg::CfgDataW-1:0] cfg_data_i
);

  logic           in_vld_d, in_vld_q;
  rle_pkg::in_t   in_q;
  logic           out_vld_d, out_vld_q;
  rle_pkg::out_t  out_q;

  logic           in_take;   // input word accepted this cycle
  logic           adv;       // buffered word goes through the update pass
  rle_pkg::cfg_t  cfg;
  rle_pkg::view_t view;
  rle_pkg::out_t  result;

  // the buffered word moves on when the output register is empty or drains
  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  assign in_vld_d  = in_take | (in_vld_q & ~adv);
  assign out_vld_d = adv | (out_vld_q & out_stall_i);

  assign cfg_ready_o = 1'b1;

  rle_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i && cfg_ready_o),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // lamp state, updated once per word that leaves the input register
  rle_effect u_effect (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .item_i (in_q),
    .cfg_i  (cfg),
    .view_o (view)
  );

  rle_scale u_scale (
    .view_i (view),
    .data_o (result)
  );

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (adv) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // a word that passes the update stage shows up as a result next cycle
  `ASSERT_CLK(a_adv_to_out, adv |=> out_valid_o, "word lost between stages")
  // no word is taken while the input register holds one that cannot move
  `ASSERT_CLK(a_no_overrun, (in_vld_q && out_vld_q && out_stall_i) |-> !in_take,
              "input register overrun")
  // power level stays saturated whatever the effect does
  `ASSERT_CLK(a_level_range, view.level <= rle_pkg::FULL_LEVEL, "power level above full")

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the rgb lamp effect engine
// ---------------------------------------------------------------------------
// Every accepted input word is run through a cycle-free model of the lamp
// (modes, dividers, save and restore, power scaling). The model's answer is
// queued and compared field by field with each result word in order. Both
// channels idle and stall at random. Directed words cover the commands and
// their corner cases, then random effect runs follow under the reset speeds,
// the fastest and slowest speeds and a few random speed settings.
// ---------------------------------------------------------------------------
module tb_top;
  import rle_pkg::*;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_t                out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  rgb_led_effect_engine u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // bookkeeping
  out_t        expected_duty_q[$];
  int unsigned words_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned settings_used  = 1;
  int unsigned errors         = 0;
  // when set, neither side idles (back-to-back stretches)
  bit          calm           = 1'b0;

  // lamp model state
  mode_e       mdl_mode, mdl_last_fx;
  logic [2:0]  mdl_phase;
  logic [15:0] mdl_ticks;
  logic [23:0] mdl_colour, mdl_stash_colour;
  logic [6:0]  mdl_level, mdl_stash_level;
  logic        mdl_on;
  cfg_t        mdl_speed;

  // ---------------------------------------------------------------------------
  // clock and time limit
  // ---------------------------------------------------------------------------
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // far beyond the slowest legal run
  initial begin
    #(10_000_000);
    $display("tb_top failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // lamp model
  // ---------------------------------------------------------------------------
  task automatic lamp_reset();
    mdl_mode         = MODE_CONST;
    mdl_last_fx      = MODE_CONST;
    mdl_phase        = '0;
    mdl_ticks        = '0;
    mdl_colour       = COL_WHITE;
    mdl_level        = RST_LEVEL;
    mdl_stash_colour = '0;
    mdl_stash_level  = '0;
    mdl_on           = 1'b0;
    mdl_speed        = '{RST_FLASH_RATE, RST_STROBE_RATE, RST_FADE_RATE,
                         RST_SMOOTH_RATE, RST_WAKEUP};
  endtask

  // tick divider: fires once the count reaches the threshold
  task automatic div_fire(input int limit, output bit fire);
    if (int'(mdl_ticks) < limit) begin
      mdl_ticks++;
      fire = 1'b0;
    end else begin
      mdl_ticks = '0;
      fire      = 1'b1;
    end
  endtask

  // first tick of an effect: stash the constant look if coming from constant
  task automatic enter_fx(input mode_e m);
    if (mdl_last_fx == MODE_CONST) begin
      mdl_stash_colour = mdl_colour;
      mdl_stash_level  = mdl_level;
    end
    mdl_ticks   = '0;
    mdl_last_fx = m;
  endtask

  task automatic lamp_tick();
    bit fire;
    // back in constant: restore the stashed look
    if (mdl_mode == MODE_CONST && mdl_last_fx != MODE_CONST) begin
      mdl_last_fx = MODE_CONST;
      mdl_colour  = mdl_stash_colour;
      mdl_level   = mdl_stash_level;
    end
    // effects freeze while the lamp is off
    if (mdl_on) begin
      case (mdl_mode)
        MODE_RGB_CYCLE: begin
          if (mdl_last_fx != MODE_RGB_CYCLE) begin
            enter_fx(MODE_RGB_CYCLE);
            mdl_phase  = 3'd0;
            mdl_colour = COL_RED;
          end
          div_fire(100 - int'($signed(mdl_speed.flash_rate)), fire);
          if (fire) begin
            mdl_phase  = (mdl_phase >= 3'd2) ? 3'd0 : mdl_phase + 3'd1;
            mdl_colour = (mdl_phase == 3'd0) ? COL_RED :
                         (mdl_phase == 3'd1) ? COL_GREEN : COL_BLUE;
          end
        end
        MODE_BLINK: begin
          if (mdl_last_fx != MODE_BLINK) begin
            enter_fx(MODE_BLINK);
            mdl_phase  = 3'd0;
            mdl_colour = COL_WHITE;
          end
          div_fire(100 - int'($signed(mdl_speed.strobe_rate)), fire);
          if (fire) begin
            mdl_phase  = (mdl_phase == 3'd0) ? 3'd1 : 3'd0;
            mdl_colour = (mdl_phase != 3'd0) ? COL_WHITE : COL_BLACK;
          end
        end
        MODE_BREATHE: begin
          if (mdl_last_fx != MODE_BREATHE) begin
            enter_fx(MODE_BREATHE);
            mdl_phase  = 3'd1;
            mdl_colour = COL_WHITE;
            mdl_level  = '0;
          end
          div_fire(100 - int'(mdl_speed.fade_rate), fire);
          if (fire) begin
            // phase nonzero: going up
            if (mdl_phase != 3'd0) begin
              if (mdl_level < FULL_LEVEL) mdl_level++;
            end else if (mdl_level > 7'd0) begin
              mdl_level--;
            end
            if (mdl_level >= FULL_LEVEL) mdl_phase = 3'd0;
            else if (mdl_level == 7'd0) mdl_phase = 3'd1;
          end
        end
        MODE_WHEEL: begin
          if (mdl_last_fx != MODE_WHEEL) begin
            enter_fx(MODE_WHEEL);
            mdl_phase  = 3'd0;
            mdl_colour = COL_RED;
          end
          div_fire(100 - int'(mdl_speed.smooth_rate), fire);
          // six-leg colour wheel, 24 bit wrap
          if (fire) begin
            case (mdl_phase)
              3'd0: if (mdl_colour == COL_YELLOW) mdl_phase = 3'd1;
                    else mdl_colour = mdl_colour + STEP_G;
              3'd1: if (mdl_colour == COL_GREEN) mdl_phase = 3'd2;
                    else mdl_colour = mdl_colour - STEP_R;
              3'd2: if (mdl_colour == COL_CYAN) mdl_phase = 3'd3;
                    else mdl_colour = mdl_colour + STEP_B;
              3'd3: if (mdl_colour == COL_BLUE) mdl_phase = 3'd4;
                    else mdl_colour = mdl_colour - STEP_G;
              3'd4: if (mdl_colour == COL_MAGENTA) mdl_phase = 3'd5;
                    else mdl_colour = mdl_colour + STEP_R;
              3'd5: if (mdl_colour == COL_RED) mdl_phase = 3'd0;
                    else mdl_colour = mdl_colour - STEP_B;
              default: mdl_phase = 3'd0;
            endcase
          end
        end
        MODE_WAKE: begin
          if (mdl_last_fx != MODE_WAKE) begin
            enter_fx(MODE_WAKE);
            mdl_colour = COL_BLUE;
            mdl_level  = '0;
          end
          div_fire(int'(mdl_speed.wakeup_period), fire);
          if (fire) begin
            if (mdl_level < FULL_LEVEL) mdl_level++;
            // full blue reached: hand over to constant
            if (mdl_level >= FULL_LEVEL) begin
              mdl_stash_colour = mdl_colour;
              mdl_stash_level  = mdl_level;
              mdl_mode         = MODE_CONST;
            end
          end
        end
        default: ;
      endcase
    end
  endtask

  function automatic logic [7:0] duty(input logic [7:0] ch);
    return mdl_on ? 8'((int'(ch) * int'(mdl_level)) / int'(FULL_LEVEL)) : 8'd0;
  endfunction

  task automatic lamp_step(input in_t w, output out_t r);
    case (w.action)
      ACT_TICK:   lamp_tick();
      ACT_MODE:   if (w.value <= 24'(MODE_WAKE)) mdl_mode = mode_e'(w.value[2:0]);
      ACT_COLOUR: mdl_colour = w.value;
      ACT_POWER:  mdl_level = (w.value > 24'(FULL_LEVEL)) ? FULL_LEVEL : w.value[6:0];
      ACT_ONOFF:  mdl_on = w.value[0];
      default: ;
    endcase
    r.red_duty   = duty(mdl_colour[23:16]);
    r.green_duty = duty(mdl_colour[15:8]);
    r.blue_duty  = duty(mdl_colour[7:0]);
    r.mode_now   = mdl_mode;
  endtask

  // ---------------------------------------------------------------------------
  // scoreboard: predicts on input words, checks result words
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : scoreboard
    out_t want;
    if (!rst_ni) begin
      lamp_reset();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_FLASH_RATE:    mdl_speed.flash_rate    = cfg_data_i[7:0];
          CFG_STROBE_RATE:   mdl_speed.strobe_rate   = cfg_data_i[7:0];
          CFG_FADE_RATE:     mdl_speed.fade_rate     = cfg_data_i[6:0];
          CFG_SMOOTH_RATE:   mdl_speed.smooth_rate   = cfg_data_i[6:0];
          CFG_WAKEUP_PERIOD: mdl_speed.wakeup_period = cfg_data_i;
          default: ;
        endcase
      end
      // input first, so a same-edge result still finds its expectation
      if (in_valid_i && !in_stall_o) begin
        lamp_step(in_data_i, want);
        expected_duty_q.push_back(want);
      end
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_duty_q.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          want = expected_duty_q.pop_front();
          check_field("red_duty",   want.red_duty,   out_data_o.red_duty);
          check_field("green_duty", want.green_duty, out_data_o.green_duty);
          check_field("blue_duty",  want.blue_duty,  out_data_o.blue_duty);
          check_field("mode_now",   want.mode_now,   out_data_o.mode_now);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: random stall before each word
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 6);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  // one word; valid stays high after acceptance so the next word can follow
  task automatic send_word(input logic [2:0] act, input logic [23:0] val);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= {act, val};
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  // drop valid and let every result drain before touching the registers
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (results_seen < words_sent) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_speeds(input logic [7:0] fl, input logic [7:0] st,
                            input logic [6:0] fa, input logic [6:0] sm,
                            input logic [15:0] wk);
    wait_idle();
    write_reg(CFG_FLASH_RATE,    {8'h00, fl});
    write_reg(CFG_STROBE_RATE,   {8'h00, st});
    write_reg(CFG_FADE_RATE,     {9'h000, fa});
    write_reg(CFG_SMOOTH_RATE,   {9'h000, sm});
    write_reg(CFG_WAKEUP_PERIOD, wk);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // any command word; colours often sit a few steps off a wheel corner
  task automatic random_command(output logic [2:0] act, output logic [23:0] val);
    int unsigned pick;
    logic [23:0] step;
    pick = $urandom_range(0, 99);
    val  = 24'($urandom());
    if (pick < 30) begin
      act = ACT_COLOUR;
      if ($urandom_range(0, 1) != 0) begin
        case ($urandom_range(0, 5))
          0: val = COL_RED;
          1: val = COL_YELLOW;
          2: val = COL_GREEN;
          3: val = COL_CYAN;
          4: val = COL_BLUE;
          default: val = COL_MAGENTA;
        endcase
        case ($urandom_range(0, 2))
          0: step = STEP_R;
          1: step = STEP_G;
          default: step = STEP_B;
        endcase
        if ($urandom_range(0, 1) != 0) val = val + 24'($urandom_range(0, 3)) * step;
        else val = val - 24'($urandom_range(0, 3)) * step;
      end
    end else if (pick < 55) begin
      act = ACT_POWER;
      if ($urandom_range(0, 1) != 0) val = 24'($urandom_range(0, 100));
    end else if (pick < 75) begin
      act    = ACT_ONOFF;
      val[0] = ($urandom_range(0, 4) != 0);
    end else if (pick < 85) begin
      act = ACT_MODE;
      if ($urandom_range(0, 3) != 0) val = 24'($urandom_range(0, 5));
    end else if (pick < 90) begin
      act = ACT_TICK;
    end else begin
      act = 3'($urandom_range(5, 7));
    end
  endtask

  // mostly effect runs (mode word then a string of ticks), some pure noise
  task automatic run_traffic(input int unsigned n_words);
    int unsigned done_cnt;
    int unsigned seg_len;
    logic [2:0]  act;
    logic [23:0] val;
    done_cnt = 0;
    while (done_cnt < n_words) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 3) != 0) begin
          send_word(ACT_ONOFF, 24'($urandom()) | 24'd1);
          done_cnt++;
        end
        val = ($urandom_range(0, 15) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 5));
        send_word(ACT_MODE, val);
        done_cnt++;
        // long runs let slow dividers and the wake-up ramp finish
        seg_len = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 120)
                                               : $urandom_range(1, 20);
        if (done_cnt + seg_len > n_words) begin
          seg_len = (done_cnt < n_words) ? n_words - done_cnt : 0;
        end
        repeat (seg_len) begin
          if ($urandom_range(0, 99) < 92) begin
            send_word(ACT_TICK, 24'($urandom()));
          end else begin
            random_command(act, val);
            send_word(act, val);
          end
        end
        done_cnt += seg_len;
      end else begin
        seg_len = $urandom_range(1, 10);
        if (done_cnt + seg_len > n_words) seg_len = n_words - done_cnt;
        repeat (seg_len) begin
          random_command(act, val);
          send_word(act, val);
        end
        done_cnt += seg_len;
      end
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // reset look, power saturation, colour extremes, on/off by bit 0 only
  task automatic test_commands();
    send_word(ACT_TICK,   24'h000000);
    send_word(ACT_ONOFF,  24'h000001);
    send_word(ACT_POWER,  24'd0);
    send_word(ACT_POWER,  24'd101);
    send_word(ACT_POWER,  24'hFFFFFF);
    send_word(ACT_COLOUR, 24'h000000);
    send_word(ACT_COLOUR, 24'hFFFFFF);
    send_word(ACT_ONOFF,  24'hFFFFFE);
    send_word(ACT_ONOFF,  24'h000001);
  endtask

  // mode above five and unknown action codes change nothing
  task automatic test_ignored_words();
    send_word(ACT_MODE, 24'd6);
    send_word(ACT_MODE, 24'hFFFFFF);
    send_word(3'd5,     24'hFFFFFF);
    send_word(3'd7,     24'h000000);
  endtask

  // entry of every effect, re-entry without restore, freeze while off,
  // restore on the first tick back in constant
  task automatic test_effect_entry();
    send_word(ACT_MODE,  24'(MODE_RGB_CYCLE));
    send_word(ACT_TICK,  24'h0);
    send_word(ACT_MODE,  24'(MODE_CONST));
    send_word(ACT_MODE,  24'(MODE_RGB_CYCLE));
    send_word(ACT_TICK,  24'h0);
    send_word(ACT_MODE,  24'(MODE_BLINK));
    send_word(ACT_TICK,  24'h0);
    send_word(ACT_MODE,  24'(MODE_BREATHE));
    send_word(ACT_TICK,  24'h0);
    send_word(ACT_ONOFF, 24'h0);
    send_word(ACT_TICK,  24'h0);
    send_word(ACT_ONOFF, 24'h1);
    send_word(ACT_MODE,  24'(MODE_WHEEL));
    send_word(ACT_TICK,  24'h0);
    send_word(ACT_MODE,  24'(MODE_WAKE));
    send_word(ACT_TICK,  24'h0);
    send_word(ACT_MODE,  24'(MODE_CONST));
    send_word(ACT_TICK,  24'h0);
  endtask

  task automatic test_default_speeds();
    run_traffic(100);
  endtask

  // zero thresholds for breathe, wheel and wake-up: those effects step on every tick
  task automatic test_fastest_speeds();
    set_speeds(8'sd50, 8'sd50, 7'd100, 7'd100, 16'd0);
    run_traffic(100);
  endtask

  task automatic test_slowest_speeds();
    set_speeds(-8'sd100, -8'sd100, 7'd70, 7'd76, 16'hFFFF);
    run_traffic(100);
  endtask

  // random speeds; wake-up period kept short most of the time
  task automatic test_random_speeds();
    int fl;
    int st;
    repeat (3) begin
      fl = int'($urandom_range(0, 150)) - 100;
      st = int'($urandom_range(0, 150)) - 100;
      set_speeds(8'(fl), 8'(st), 7'($urandom_range(70, 100)), 7'($urandom_range(76, 100)),
                 ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 3)));
      run_traffic(100);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_commands();
    test_ignored_words();
    test_effect_entry();
    test_default_speeds();
    test_fastest_speeds();
    test_slowest_speeds();
    test_random_speeds();

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (expected_duty_q.size() != 0) begin
      $error("%0d expected result words never arrived", expected_duty_q.size());
      errors++;
    end
    $display("%0d words sent, %0d result words checked, %0d speed settings",
             words_sent, results_seen, settings_used);
    $display("commands, ignored words and all six modes under random gaps and stalls");
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
